// File: rtl/core/ffpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and codes for the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int START_W = 16;
  localparam int LEN_W   = 17;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3; // unused code, passes through

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  // one table entry
  typedef struct packed {
    logic               vld;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } ext_t;

  // command broadcast to every cell at once
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_SHR   = 2'd1; // shift right from pos, write new at pos
  localparam logic [1:0] OP_SHL   = 2'd2; // shift left from pos (remove pos)
  localparam logic [1:0] OP_WR    = 2'd3; // overwrite entry pos

  typedef struct packed {
    logic [1:0]         op;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } cell_cmd_t;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ffpa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_cell
// One slot of the extent table. Holds an entry and takes a neighbor's entry
// on insert or remove shifts.
// ----------------------------------------------------------------------------
module ffpa_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              sel,      // this slot is the target position
  input  wire logic              above,    // slot index is above the target
  input  ffpa_pkg::cell_cmd_t    cmd,
  input  ffpa_pkg::ext_t         left_in,  // entry of slot i-1
  input  ffpa_pkg::ext_t         right_in, // entry of slot i+1
  output ffpa_pkg::ext_t         ent
);
  ffpa_pkg::ext_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      ffpa_pkg::OP_SHR: begin
        if (sel) ent_nxt = '{vld: 1'b1, start: cmd.start, len: cmd.len};
        else if (above) ent_nxt = left_in;
      end
      ffpa_pkg::OP_SHL: begin
        if (sel || above) ent_nxt = right_in;
      end
      ffpa_pkg::OP_WR: begin
        if (sel) ent_nxt = '{vld: 1'b1, start: cmd.start, len: cmd.len};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ent_r.vld <= 1'b0;
    else        ent_r.vld <= ent_nxt.vld;
    ent_r.start <= ent_nxt.start;
    ent_r.len   <= ent_nxt.len;
  end

  assign ent = ent_r;
endmodule
`default_nettype wire

// File: rtl/core/first_fit_page_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_page_allocator_unit
// First-fit page allocator over a sorted row of free-extent cells.
// ----------------------------------------------------------------------------
// One item at a time. An item is accepted in the idle state, then scanned one
// slot per cycle (read through a registered probe of the cell row; the last
// scan step issues the shift or rewrite that every cell applies in parallel),
// then handed to the output register in the done state, which also removes
// the successor after a merge with both neighbors. Zero-count and unused-mode
// items end the scan at its first step. The output register lets the next
// item be taken while a result waits; the hand-off stalls only while the
// previous result is still untaken.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_unit #(
  parameter int MAX_EXTENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // mode[1:0], start_page[17:2], page_count[34:18]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // status[1:0], granted_page[17:2], free_pages_left[34:18]
);
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int SW = ffpa_pkg::START_W;
  localparam int LW = ffpa_pkg::LEN_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    mode_r;
  logic [SW-1:0] base_r;
  logic [LW-1:0] n_r;
  logic [CW-1:0] idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic [LW-1:0] total_r, total_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [SW-1:0] ogr_r, ogr_nxt;
  logic [1:0]    res_st_r;
  logic [SW-1:0] res_gr_r;
  logic [LW-1:0] res_tot_r;
  logic          res_load;

  ffpa_pkg::ext_t    ent [MAX_EXTENTS];
  ffpa_pkg::cell_cmd_t cmd, cmd_q;
  logic [IW-1:0]     pos, pos_q;

  genvar g;
  generate
    for (g = 0; g < MAX_EXTENTS; g++) begin : g_cell
      ffpa_pkg::ext_t lft, rgt;
      if (g == 0) begin : g_l0
        assign lft = '0;
      end else begin : g_l
        assign lft = ent[g-1];
      end
      if (g == MAX_EXTENTS - 1) begin : g_rN
        assign rgt = '0;
      end else begin : g_r
        assign rgt = ent[g+1];
      end
      ffpa_cell u_cell (
        .clk(clk), .rst_n(rst_n),
        .sel(pos_q == IW'(g)), .above(IW'(g) > pos_q),
        .cmd(cmd_q), .left_in(lft), .right_in(rgt), .ent(ent[g])
      );
    end
  endgenerate

  // scan probes: current slot and its predecessor, registered from the
  // address of the next cycle
  logic [IW-1:0]  ci, pi, nci, npi;
  ffpa_pkg::ext_t cur, prv, cur_r, prv_r;
  logic           at_end, has_prev, pm, sm;
  logic [LW:0]    bend;
  assign ci  = idx_r[IW-1:0];
  assign pi  = ci - IW'(1);
  assign nci = idx_nxt[IW-1:0];
  assign npi = nci - IW'(1);
  assign cur = cur_r;
  assign prv = prv_r;
  assign at_end   = (idx_r == cnt_r);
  assign has_prev = (idx_r != '0);
  assign bend = {1'b0, n_r} + {{(LW+1-SW){1'b0}}, base_r};

  logic [LW:0] prv_end;
  assign prv_end = {{(LW+1-SW){1'b0}}, prv.start} + {1'b0, prv.len};
  assign pm = has_prev && (prv_end == {{(LW+1-SW){1'b0}}, base_r});
  assign sm = !at_end && (bend == {{(LW+1-SW){1'b0}}, cur.start});

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    ovalid_nxt = ovalid_r;
    ost_nxt    = ost_r;
    ogr_nxt    = ogr_r;
    cmd        = '{op: ffpa_pkg::OP_NONE, start: base_r, len: n_r};
    pos        = ci;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        ost_nxt = ffpa_pkg::ST_OK;
        ogr_nxt = '0;
        if (mode_r == ffpa_pkg::MODE_NOP) begin
          state_nxt = S_DONE;
        end else if (n_r == '0) begin
          ost_nxt   = ffpa_pkg::ST_ZERO;
          state_nxt = S_DONE;
        end else if (mode_r == ffpa_pkg::MODE_ALLOC) begin
          if (n_r > total_r || at_end) begin
            ost_nxt   = ffpa_pkg::ST_NOFIT;
            state_nxt = S_DONE;
          end else if (cur.len >= n_r) begin
            ogr_nxt   = cur.start;
            total_nxt = total_r - n_r;
            state_nxt = S_DONE;
            if (cur.len == n_r) begin
              cmd.op  = ffpa_pkg::OP_SHL;
              cnt_nxt = cnt_r - CW'(1);
            end else begin
              cmd = '{op: ffpa_pkg::OP_WR, start: cur.start + n_r[SW-1:0],
                      len: cur.len - n_r};
            end
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end else if (!at_end && cur.start <= base_r) begin
          idx_nxt = idx_r + CW'(1);
        end else begin
          // insertion point found at idx_r
          state_nxt = S_DONE;
          if (mode_r == ffpa_pkg::MODE_FREE && pm && sm) begin
            pos = pi;
            cmd = '{op: ffpa_pkg::OP_WR, start: prv.start,
                    len: ffpa_pkg::sat_add(prv.len, ffpa_pkg::sat_add(n_r, cur.len))};
            total_nxt = ffpa_pkg::sat_add(total_r, n_r);
          end else if (mode_r == ffpa_pkg::MODE_FREE && pm) begin
            pos = pi;
            cmd = '{op: ffpa_pkg::OP_WR, start: prv.start,
                    len: ffpa_pkg::sat_add(prv.len, n_r)};
            total_nxt = ffpa_pkg::sat_add(total_r, n_r);
          end else if (mode_r == ffpa_pkg::MODE_FREE && sm) begin
            cmd = '{op: ffpa_pkg::OP_WR, start: base_r,
                    len: ffpa_pkg::sat_add(cur.len, n_r)};
            total_nxt = ffpa_pkg::sat_add(total_r, n_r);
          end else if (cnt_r == CW'(MAX_EXTENTS)) begin
            ost_nxt = ffpa_pkg::ST_FULL;
          end else begin
            cmd.op    = ffpa_pkg::OP_SHR;
            cnt_nxt   = cnt_r + CW'(1);
            total_nxt = ffpa_pkg::sat_add(total_r, n_r);
          end
        end
      end
      S_DONE: begin
        // the successor is removed after the double merge wrote its predecessor
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_load = (state_r == S_DONE) && (!ovalid_r || out_tready);

  // double merge: remove the successor in the cycle after the predecessor is written
  logic rm_r;
  logic [IW-1:0] rm_pos_r;
  logic rm_nxt;
  assign rm_nxt = (state_r == S_SCAN) && (mode_r == ffpa_pkg::MODE_FREE) && n_r != '0 &&
                  !(!at_end && cur.start <= base_r) && pm && sm;

  always_comb begin
    cmd_q = cmd;
    pos_q = pos;
    if (rm_r) begin
      cmd_q = '{op: ffpa_pkg::OP_SHL, start: base_r, len: n_r};
      pos_q = rm_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      total_r  <= '0;
      ovalid_r <= 1'b0;
      rm_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= rm_nxt ? cnt_r - CW'(1) : cnt_nxt;
      total_r  <= total_nxt;
      ovalid_r <= ovalid_nxt;
      rm_r     <= rm_nxt;
    end
    rm_pos_r <= ci;
    idx_r    <= idx_nxt;
    ost_r    <= ost_nxt;
    ogr_r    <= ogr_nxt;
    cur_r    <= ent[nci];
    prv_r    <= ent[npi];
    if (res_load) begin
      res_st_r  <= ost_r;
      res_gr_r  <= ogr_r;
      res_tot_r <= total_r;
    end
    if (in_tvalid && in_tready) begin
      mode_r <= in_tdata[1:0];
      base_r <= in_tdata[17:2];
      n_r    <= in_tdata[34:18];
    end
  end

  assign in_tready  = (state_r == S_IDLE) && !rm_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, res_tot_r, res_gr_r, res_st_r};

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_EXTENTS)) else $error("extent count overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !in_tready) else $error("ready while scanning");
  a_rm: assert property (@(posedge clk) disable iff (!rst_n)
    rm_r |-> $past(state_r == S_SCAN)) else $error("stray remove");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit page allocator: a predictor keeps its
// own extent table, and every result transfer is compared with the oldest
// predicted one.
// ----------------------------------------------------------------------------

// field order follows out_tdata from the top bit down
typedef struct packed {
  logic [ffpa_pkg::LEN_W-1:0]   left;
  logic [ffpa_pkg::START_W-1:0] granted;
  logic [1:0]                   status;
} alloc_reply_t;

class alloc_scoreboard;
  logic [ffpa_pkg::START_W-1:0] ext_base[$];
  logic [ffpa_pkg::LEN_W-1:0]   ext_len[$];
  logic [ffpa_pkg::LEN_W-1:0]   pages_free;
  int                 table_depth;
  alloc_reply_t       pending[$];
  int                 mismatches;
  int                 checked;
  int                 grants;
  int                 merges;
  int                 fulls;

  function new(int depth);
    table_depth = depth;
    pages_free = '0;
    mismatches = 0;
    checked = 0;
    grants = 0;
    merges = 0;
    fulls = 0;
  endfunction

  function int sorted_slot(logic [ffpa_pkg::START_W-1:0] b);
    int i;
    i = 0;
    while (i < ext_base.size() && ext_base[i] <= b) i++;
    return i;
  endfunction

  function void note_request(logic [1:0] mode, logic [ffpa_pkg::START_W-1:0] b,
                             logic [ffpa_pkg::LEN_W-1:0] n);
    alloc_reply_t r;
    int i;
    bit pm, sm;
    r = '0;
    if (mode != ffpa_pkg::MODE_NOP && n == 0) begin
      r.status = ffpa_pkg::ST_ZERO;
    end else if (mode == ffpa_pkg::MODE_ADD) begin
      if (ext_base.size() >= table_depth) begin
        r.status = ffpa_pkg::ST_FULL;
        fulls++;
      end else begin
        i = sorted_slot(b);
        ext_base.insert(i, b);
        ext_len.insert(i, n);
        pages_free = ffpa_pkg::sat_add(pages_free, n);
      end
    end else if (mode == ffpa_pkg::MODE_ALLOC) begin
      i = 0;
      if (n > pages_free) begin
        r.status = ffpa_pkg::ST_NOFIT;
      end else begin
        while (i < ext_len.size() && ext_len[i] < n) i++;
        if (i >= ext_len.size()) begin
          r.status = ffpa_pkg::ST_NOFIT;
        end else begin
          grants++;
          r.granted = ext_base[i];
          if (ext_len[i] == n) begin
            ext_base.delete(i);
            ext_len.delete(i);
          end else begin
            ext_base[i] = ext_base[i] + n[ffpa_pkg::START_W-1:0];
            ext_len[i] = ext_len[i] - n;
          end
          pages_free = pages_free - n;
        end
      end
    end else if (mode == ffpa_pkg::MODE_FREE) begin
      i = sorted_slot(b);
      pm = i > 0 && ({1'b0, ext_base[i-1]} + {1'b0, ext_len[i-1]}) == {2'b0, b};
      sm = i < ext_base.size() && ({1'b0, b} + {1'b0, n}) == {2'b0, ext_base[i]};
      if (pm || sm) merges++;
      if (pm && sm) begin
        ext_len[i-1] = ffpa_pkg::sat_add(ext_len[i-1], ffpa_pkg::sat_add(n, ext_len[i]));
        ext_base.delete(i);
        ext_len.delete(i);
        pages_free = ffpa_pkg::sat_add(pages_free, n);
      end else if (pm) begin
        ext_len[i-1] = ffpa_pkg::sat_add(ext_len[i-1], n);
        pages_free = ffpa_pkg::sat_add(pages_free, n);
      end else if (sm) begin
        ext_base[i] = b;
        ext_len[i] = ffpa_pkg::sat_add(ext_len[i], n);
        pages_free = ffpa_pkg::sat_add(pages_free, n);
      end else if (ext_base.size() >= table_depth) begin
        r.status = ffpa_pkg::ST_FULL;
        fulls++;
      end else begin
        ext_base.insert(i, b);
        ext_len.insert(i, n);
        pages_free = ffpa_pkg::sat_add(pages_free, n);
      end
    end
    r.left = pages_free;
    pending.push_back(r);
  endfunction

  function void check_reply(alloc_reply_t got);
    alloc_reply_t want;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result transfer: status=%0d granted=%0d left=%0d",
                 got.status, got.granted, got.left);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp status=%0d granted=%0d left=%0d, got %0d %0d %0d",
                 want.status, want.granted, want.left, got.status, got.granted,
                 got.left);
    end
  endfunction
endclass

module testbench;
  localparam int DEPTH = 64;
  localparam int LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  alloc_scoreboard sb;
  int  cycle_count;
  bit  calm;          // no idling on either side
  int  hold_off;      // receiver long stall, in cycles
  int  sent;

  first_fit_page_allocator_unit #(.MAX_EXTENTS(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: random stall, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready && rst_n)
        sb.check_reply(out_tdata[34:0]);
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
      end
    end
  end

  // leaves tvalid high after the transfer; the next call reloads it or drops it for a gap, drain() drops it
  task automatic send_item(logic [1:0] mode, logic [15:0] b, logic [16:0] n);
    while (!calm && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, n, b, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(mode, b, n);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
  endtask

  task automatic rand_item(int spread);
    int k;
    logic [16:0] n;
    k = $urandom_range(99);
    n = ($urandom_range(19) == 0) ? 17'($urandom) : 17'($urandom_range(spread));
    if (k < 5) send_item(ffpa_pkg::MODE_NOP, 16'($urandom), 17'($urandom));
    else if (k < 30) send_item(ffpa_pkg::MODE_ADD, 16'($urandom_range(255) * 256), n);
    else if (k < 65) send_item(ffpa_pkg::MODE_ALLOC, 16'($urandom), n);
    else send_item(ffpa_pkg::MODE_FREE, 16'($urandom_range(1023) * 64), n);
  endtask

  initial begin
    sb = new(DEPTH);
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    calm = 1'b0;
    hold_off = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero counts, unused mode, empty-table alloc, extremes, merges
    send_item(ffpa_pkg::MODE_ADD, 16'd0, 17'd0);
    send_item(ffpa_pkg::MODE_ALLOC, 16'd5, 17'd1);
    send_item(ffpa_pkg::MODE_NOP, 16'hFFFF, 17'h1FFFF);
    send_item(ffpa_pkg::MODE_ADD, 16'hFFFF, 17'h1FFFF);
    send_item(ffpa_pkg::MODE_ADD, 16'd100, 17'd10);
    send_item(ffpa_pkg::MODE_ADD, 16'd100, 17'd20);   // equal start goes after
    send_item(ffpa_pkg::MODE_ALLOC, 16'd0, 17'd20);
    send_item(ffpa_pkg::MODE_ALLOC, 16'd0, 17'd10);   // exact fit
    send_item(ffpa_pkg::MODE_ALLOC, 16'hFFFF, 17'd3); // remainder wraps past 65535
    send_item(ffpa_pkg::MODE_FREE, 16'd200, 17'd10);
    send_item(ffpa_pkg::MODE_FREE, 16'd190, 17'd10);  // successor merge
    send_item(ffpa_pkg::MODE_FREE, 16'd210, 17'd5);   // predecessor merge
    send_item(ffpa_pkg::MODE_FREE, 16'd220, 17'd5);
    send_item(ffpa_pkg::MODE_FREE, 16'd215, 17'd5);   // both neighbors
    send_item(ffpa_pkg::MODE_FREE, 16'd0, 17'h10000);
    send_item(ffpa_pkg::MODE_ALLOC, 16'd0, 17'h1FFFF);
    send_item(ffpa_pkg::MODE_ALLOC, 16'd0, 17'h10000);
    send_item(ffpa_pkg::MODE_FREE, 16'hFFF0, 17'h1FFFF); // saturating totals
    send_item(ffpa_pkg::MODE_ALLOC, 16'd0, 17'd0);
    drain();

    // fill the table, then hit full on add and on unmerged free
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(ffpa_pkg::MODE_ADD, 16'(i * 1000), 17'd3);
    send_item(ffpa_pkg::MODE_FREE, 16'd500, 17'd4);
    send_item(ffpa_pkg::MODE_FREE, 16'd3, 17'd2);     // merges even when full
    drain();

    // long receiver stall while input keeps coming
    hold_off = 300;
    for (int i = 0; i < 40; i++)
      send_item(ffpa_pkg::MODE_ALLOC, 16'd0, 17'($urandom_range(4)));
    drain();

    // random: churn the table with small sizes, some calm stretches
    while (sent < 1300) begin
      if (sent % 200 == 100) calm = 1'b1;
      if (sent % 200 == 160) calm = 1'b0;
      rand_item(sent % 400 < 200 ? 64 : 4096);
    end
    calm = 1'b0;
    drain();

    $display("%0d items sent, %0d results checked: %0d grants, %0d merging frees,",
             sent, sb.checked, sb.grants, sb.merges);
    $display("%0d table-full outcomes, final free total %0d", sb.fulls, sb.pages_free);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
